[sv/hrlc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_pkg
// Shared types, widths and codes for the request line checker.
// ----------------------------------------------------------------------------
package hrlc_pkg;

  localparam int unsigned LenW   = 12;
  localparam int unsigned CountW = LenW + 1;
  localparam logic [LenW-1:0] MaxUriReset = 12'd1024;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChZero  = 8'h00;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChH     = 8'h48;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StBad  = 2'd1;
  localparam logic [1:0] StJunk = 2'd2;

  // one classified input item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_space;
    logic       is_crlf;
    logic       is_zero;
  } item_t;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] head_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h48;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h41;
      default: c = 8'h44;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2f;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2e;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

endpackage

[sv/hrlc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_front
// Accepts input bytes and tags each with its character class.
// ----------------------------------------------------------------------------
module hrlc_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // data_byte
  input  logic              s_axis_tlast,   // last_byte
  input  logic              full_i,
  output logic              push_o,
  output hrlc_pkg::item_t   item_o
);
  import hrlc_pkg::*;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    item_o.data     = s_axis_tdata;
    item_o.last     = s_axis_tlast;
    item_o.is_space = (s_axis_tdata == ChSpace);
    item_o.is_crlf  = (s_axis_tdata == ChCr) || (s_axis_tdata == ChLf);
    item_o.is_zero  = (s_axis_tdata == ChZero);
  end

endmodule

[sv/hrlc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hrlc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrlc_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output hrlc_pkg::item_t item_o
);
  import hrlc_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[sv/hrlc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_back
// Request line state machine with a registered result stage.
// ----------------------------------------------------------------------------
module hrlc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [hrlc_pkg::LenW-1:0]  limit_i,
  input  logic                       valid_i,
  input  hrlc_pkg::item_t            item_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // uri_valid, uri_byte, status, method_kind
  output logic                       m_axis_tlast   // done_res
);
  import hrlc_pkg::*;

  localparam logic [2:0] PhSkipM = 3'd0;
  localparam logic [2:0] PhMethod = 3'd1;
  localparam logic [2:0] PhSkipU = 3'd2;
  localparam logic [2:0] PhUri   = 3'd3;
  localparam logic [2:0] PhVerNl = 3'd4;
  localparam logic [2:0] PhVerSp = 3'd5;
  localparam logic [2:0] PhVer   = 3'd6;
  localparam logic [2:0] PhTail  = 3'd7;

  logic [2:0]        phase_q, phase_d;
  logic [3:0]        idx_q, idx_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              meth_q, meth_d;
  logic [1:0]        stat_q, stat_d;
  logic              dec_q, dec_d;

  logic              ovalid_q;
  logic              uv_q, uv_d;
  logic [7:0]        ub_q, ub_d;
  logic              done_q, done_d;
  logic [1:0]        ost_q, ost_d;
  logic              mk_q, mk_d;

  function automatic logic [1:0] end_outcome(input logic [2:0] ph);
    return (ph == PhUri || ph == PhVerNl || ph == PhTail) ? StOk : StBad;
  endfunction

  assign pop_o         = valid_i && (!ovalid_q || m_axis_tready);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = done_q;
  assign m_axis_tdata  = {4'b0, mk_q, ost_q, ub_q, uv_q};

  always_comb begin
    logic [CountW-1:0] cnt_n;
    logic [2:0]        mlen;
    logic [1:0]        fin;
    phase_d = phase_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    meth_d  = meth_q;
    stat_d  = stat_q;
    dec_d   = dec_q;
    uv_d    = 1'b0;
    ub_d    = 8'd0;
    done_d  = 1'b0;
    ost_d   = StOk;
    mk_d    = 1'b0;
    mlen    = meth_q ? 3'd4 : 3'd3;
    cnt_n   = ((phase_q == PhSkipU) ? '0 : cnt_q) + 1'b1;
    fin     = StOk;

    if (!dec_q) begin
      if (item_i.is_zero) begin
        stat_d = end_outcome(phase_q);
        dec_d  = 1'b1;
      end else begin
        unique case (phase_q)
          PhSkipM: begin
            if (!item_i.is_space) begin
              if (item_i.data == ChG || item_i.data == ChH) begin
                meth_d  = (item_i.data == ChH);
                idx_d   = 4'd1;
                phase_d = PhMethod;
              end else begin
                stat_d = StBad;
                dec_d  = 1'b1;
              end
            end
          end
          PhMethod: begin
            if (item_i.is_space) begin
              if (idx_q == {1'b0, mlen}) begin
                phase_d = PhSkipU;
              end else begin
                stat_d = StBad;
                dec_d  = 1'b1;
              end
            end else if (idx_q >= {1'b0, mlen}) begin
              stat_d = StBad;
              dec_d  = 1'b1;
            end else if (item_i.data != (meth_q ? head_char(idx_q[1:0])
                                                : get_char(idx_q[1:0]))) begin
              stat_d = StBad;
              dec_d  = 1'b1;
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
          PhSkipU, PhUri: begin
            if (item_i.is_space) begin
              if (phase_q == PhUri) begin
                phase_d = PhVerNl;
              end
            end else begin
              phase_d = PhUri;
              cnt_d   = cnt_n;
              if (cnt_n > {1'b0, limit_i}) begin
                stat_d = StBad;
                dec_d  = 1'b1;
              end else begin
                uv_d = 1'b1;
                ub_d = item_i.data;
              end
            end
          end
          PhVerNl, PhVerSp: begin
            if (item_i.is_space) begin
              phase_d = PhVerSp;
            end else if (item_i.is_crlf) begin
              if (phase_q == PhVerSp) begin
                stat_d = StBad;
                dec_d  = 1'b1;
              end
            end else if (item_i.data == ver_char(3'd0)) begin
              idx_d   = 4'd1;
              phase_d = PhVer;
            end else begin
              stat_d = StBad;
              dec_d  = 1'b1;
            end
          end
          PhVer: begin
            if (item_i.data != ver_char(idx_q[2:0])) begin
              stat_d = StBad;
              dec_d  = 1'b1;
            end else begin
              idx_d = idx_q + 4'd1;
              if (idx_q == 4'd7) begin
                phase_d = PhTail;
              end
            end
          end
          default: begin
            if (item_i.is_crlf) begin
              stat_d = StOk;
              dec_d  = 1'b1;
            end else if (!item_i.is_space) begin
              stat_d = StJunk;
              dec_d  = 1'b1;
            end
          end
        endcase
      end
    end

    if (item_i.last) begin
      fin     = dec_d ? stat_d : end_outcome(phase_d);
      done_d  = 1'b1;
      ost_d   = fin;
      mk_d    = (fin == StOk) ? meth_d : 1'b0;
      phase_d = PhSkipM;
      idx_d   = 4'd0;
      cnt_d   = '0;
      meth_d  = 1'b0;
      stat_d  = StOk;
      dec_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSkipM;
      idx_q    <= 4'd0;
      cnt_q    <= '0;
      meth_q   <= 1'b0;
      stat_q   <= StOk;
      dec_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q  <= phase_d;
        idx_q    <= idx_d;
        cnt_q    <= cnt_d;
        meth_q   <= meth_d;
        stat_q   <= stat_d;
        dec_q    <= dec_d;
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      uv_q   <= uv_d;
      ub_q   <= ub_d;
      done_q <= done_d;
      ost_q  <= ost_d;
      mk_q   <= mk_d;
    end
  end

endmodule

[sv/http_request_line_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_check
// Checks an HTTP request line byte by byte, passes URI bytes out and
// reports the line status on the final byte.
// ----------------------------------------------------------------------------
// channel    dir  fields
// s_axis     in   tdata[7:0] data_byte, tlast last_byte
// m_axis     out  tdata[0] uri_valid, [8:1] uri_byte, [10:9] status,
//                 [11] method_kind, tlast done_res
// apb        in   register 0 at address 0: uri_limit[11:0]
//
// one item per cycle while the output is not stalled; each item gives one result
// (classify into a two-entry queue, then one parser step into the output
// register). reset clears the parser and sets the uri limit to 1024.
// a stalled output fills the queue, after which tready drops.
// ----------------------------------------------------------------------------
module http_request_line_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // uri_valid, uri_byte, status, method_kind
  output logic        m_axis_tlast,   // done_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hrlc_pkg::*;

  logic            full;
  logic            push;
  item_t           push_item;
  logic            q_valid;
  logic            pop;
  item_t           q_item;
  logic [LenW-1:0] max_uri_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-LenW){1'b0}}, max_uri_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_uri_q <= MaxUriReset;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      max_uri_q <= pwdata[LenW-1:0];
    end
  end

  hrlc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  hrlc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  hrlc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (max_uri_q),
    .valid_i       (q_valid),
    .item_i        (q_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a uri byte on the final item means the line ended inside the uri
  a_uri_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] && m_axis_tlast |-> m_axis_tdata[10:9] == StOk)
    else $error("uri byte on final item with bad status");

  a_method_only_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tlast && m_axis_tdata[10:9] == StOk)
    else $error("method kind outside an accepted final item");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[10:9] == StOk)
    else $error("status set before the final item");

  a_uri_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
    else $error("uri byte not cleared without uri valid");

endmodule
